>>> rtl/ritd_pkg.sv
// -----------------------------------------------------------------------------
// ritd_pkg
// Codes, register numbers and helpers for the RAM, I/O and timer device.
// -----------------------------------------------------------------------------
package ritd_pkg;

  typedef enum logic [1:0] {
    ACT_READ  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_TICK  = 2'd2
  } action_e;

  localparam int unsigned RegW = 5;
  localparam int unsigned PreW = 11;

  localparam logic [RegW-1:0] REG_PA_DATA = 5'h00;
  localparam logic [RegW-1:0] REG_PA_DIR  = 5'h01;
  localparam logic [RegW-1:0] REG_PB_DATA = 5'h02;
  localparam logic [RegW-1:0] REG_PB_DIR  = 5'h03;
  localparam logic [RegW-1:0] REG_TIMER   = 5'h04;
  localparam logic [RegW-1:0] REG_STATUS  = 5'h05;
  localparam logic [RegW-1:0] REG_LOAD1   = 5'h14;
  localparam logic [RegW-1:0] REG_LOAD8   = 5'h15;
  localparam logic [RegW-1:0] REG_LOAD64  = 5'h16;
  localparam logic [RegW-1:0] REG_LOAD1K  = 5'h17;

  localparam logic [7:0] UNMAPPED_BYTE = 8'hFF;

  // Prescale period in ticks for each select code.
  function automatic logic [PreW-1:0] prescale_period(logic [1:0] sel);
    logic [PreW-1:0] p;
    case (sel)
      2'd0:    p = 11'd1;
      2'd1:    p = 11'd8;
      2'd2:    p = 11'd64;
      default: p = 11'd1024;
    endcase
    return p;
  endfunction

  function automatic logic [7:0] mix_port(logic [7:0] latch, logic [7:0] dir,
                                          logic [7:0] pins);
    return (latch & dir) | (pins & ~dir);
  endfunction

endpackage

>>> rtl/ram_io_timer_device_core.sv
// -----------------------------------------------------------------------------
// ram_io_timer_device_core
// Scratch RAM, two I/O ports and a prescaled down counter behind one
// transaction channel; every transaction returns one result.
// -----------------------------------------------------------------------------
// Pipeline: an accepted transaction moves through the middle stage, which waits for
//   the synchronous scratch RAM read, and then through the output register.
// Throughput: one transaction per cycle unless stalled; all state updates at accept.
// Reset: rst_ni clears state and valid bits at once; RAM entries read as zero until
//   written, tracked by one valid flip-flop per entry, so there is no clearing pass.
module ram_io_timer_device_core #(
  parameter int unsigned RAM_BYTES = 128
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] action_i,
  input  logic [7:0] address_i,
  input  logic [7:0] write_data_i,
  input  logic [7:0] port_a_pins_i,
  input  logic [7:0] port_b_pins_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] read_data_o,
  output logic [7:0] port_a_drive_o,
  output logic [7:0] port_b_drive_o,
  output logic       timer_irq_o
);
  import ritd_pkg::*;

  localparam int unsigned IdxW = $clog2(RAM_BYTES);
  localparam logic [7:0] RamBytes8 = 8'(RAM_BYTES);

  // Architectural state.
  logic [7:0]      pa_latch_q, pa_latch_d;
  logic [7:0]      pb_latch_q, pb_latch_d;
  logic [7:0]      pa_dir_q, pa_dir_d;
  logic [7:0]      pb_dir_q, pb_dir_d;
  logic [7:0]      timer_q, timer_d;
  logic [1:0]      presel_q, presel_d;
  logic [PreW-1:0] precnt_q, precnt_d;
  logic            running_q, running_d;
  logic            irq_q, irq_d;

  // Scratch RAM and its per-entry written flags.
  logic [7:0]           ram_mem [RAM_BYTES];
  logic [RAM_BYTES-1:0] ram_vld_q;
  logic [7:0]           ram_rdata_q;
  logic                 ram_rvld_q;

  // Middle stage, waiting for RAM read data.
  logic       s1_valid_q;
  logic       s1_is_ram_q;
  logic [7:0] s1_rd_q;
  logic [7:0] s1_pa_q, s1_pb_q;
  logic       s1_irq_q;

  // Output register.
  logic       out_valid_q;
  logic [7:0] out_rd_q, out_pa_q, out_pb_q;
  logic       out_irq_q;

  logic            in_accept, s1_move, out_take;
  action_e         act;
  logic            is_reg;
  logic [RegW-1:0] reg_sel;
  logic [7:0]      ram_idx8;
  logic [IdxW-1:0] ram_idx;
  logic            ram_rd_en, ram_wr_en;
  logic [7:0]      rd_d;
  logic [PreW-1:0] precnt_inc;
  logic [7:0]      s1_result;

  assign act     = action_e'(action_i);
  assign is_reg  = address_i[7];
  assign reg_sel = address_i[RegW-1:0];

  // The address is below twice the RAM size, so one subtract gives the modulo.
  assign ram_idx8 = (address_i >= RamBytes8) ? (address_i - RamBytes8) : address_i;
  assign ram_idx  = ram_idx8[IdxW-1:0];

  assign out_take   = out_valid_q && !out_stall_i;
  assign s1_move    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_move;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign ram_rd_en = in_accept && !is_reg && (act == ACT_READ);
  assign ram_wr_en = in_accept && !is_reg && (act == ACT_WRITE);

  assign precnt_inc = precnt_q + 1'b1;

  always_comb begin
    pa_latch_d = pa_latch_q;
    pb_latch_d = pb_latch_q;
    pa_dir_d   = pa_dir_q;
    pb_dir_d   = pb_dir_q;
    timer_d    = timer_q;
    presel_d   = presel_q;
    precnt_d   = precnt_q;
    running_d  = running_q;
    irq_d      = irq_q;
    rd_d       = '0;
    case (act)
      ACT_READ: begin
        if (is_reg) begin
          case (reg_sel)
            REG_PA_DATA: rd_d = mix_port(pa_latch_q, pa_dir_q, port_a_pins_i);
            REG_PA_DIR:  rd_d = pa_dir_q;
            REG_PB_DATA: rd_d = mix_port(pb_latch_q, pb_dir_q, port_b_pins_i);
            REG_PB_DIR:  rd_d = pb_dir_q;
            REG_TIMER:   rd_d = timer_q;
            REG_STATUS: begin
              rd_d  = timer_q;
              irq_d = 1'b0;
            end
            default:     rd_d = UNMAPPED_BYTE;
          endcase
        end
      end
      ACT_WRITE: begin
        if (is_reg) begin
          case (reg_sel)
            REG_PA_DATA: pa_latch_d = write_data_i;
            REG_PA_DIR:  pa_dir_d   = write_data_i;
            REG_PB_DATA: pb_latch_d = write_data_i;
            REG_PB_DIR:  pb_dir_d   = write_data_i;
            REG_LOAD1, REG_LOAD8, REG_LOAD64, REG_LOAD1K: begin
              presel_d  = reg_sel[1:0];
              timer_d   = write_data_i;
              precnt_d  = '0;
              running_d = 1'b1;
              irq_d     = 1'b0;
            end
            default: ;
          endcase
        end
      end
      ACT_TICK: begin
        if (running_q) begin
          if (precnt_inc >= prescale_period(presel_q)) begin
            precnt_d = '0;
            if (timer_q == 8'd0) begin
              irq_d   = 1'b1;
              timer_d = 8'hFF;
            end else begin
              timer_d = timer_q - 8'd1;
            end
          end else begin
            precnt_d = precnt_inc;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pa_latch_q <= '0;
      pb_latch_q <= '0;
      pa_dir_q   <= '0;
      pb_dir_q   <= '0;
      timer_q    <= '0;
      presel_q   <= '0;
      precnt_q   <= '0;
      running_q  <= 1'b0;
      irq_q      <= 1'b0;
    end else if (in_accept) begin
      pa_latch_q <= pa_latch_d;
      pb_latch_q <= pb_latch_d;
      pa_dir_q   <= pa_dir_d;
      pb_dir_q   <= pb_dir_d;
      timer_q    <= timer_d;
      presel_q   <= presel_d;
      precnt_q   <= precnt_d;
      running_q  <= running_d;
      irq_q      <= irq_d;
    end
  end

  // Each transaction touches the RAM at its accept edge, so a later read always
  // sees an earlier write without forwarding.
  always_ff @(posedge clk_i) begin
    if (ram_wr_en) begin
      ram_mem[ram_idx] <= write_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_rd_en) begin
      ram_rdata_q <= ram_mem[ram_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ram_vld_q  <= '0;
      ram_rvld_q <= 1'b0;
    end else begin
      if (ram_wr_en) begin
        ram_vld_q[ram_idx] <= 1'b1;
      end
      if (ram_rd_en) begin
        ram_rvld_q <= ram_vld_q[ram_idx];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_move) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_is_ram_q <= ram_rd_en;
      s1_rd_q     <= rd_d;
      s1_pa_q     <= pa_latch_d & pa_dir_d;
      s1_pb_q     <= pb_latch_d & pb_dir_d;
      s1_irq_q    <= irq_d;
    end
  end

  assign s1_result = s1_is_ram_q ? (ram_rvld_q ? ram_rdata_q : 8'd0) : s1_rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_move) begin
      out_valid_q <= 1'b1;
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      out_rd_q  <= s1_result;
      out_pa_q  <= s1_pa_q;
      out_pb_q  <= s1_pb_q;
      out_irq_q <= s1_irq_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign read_data_o    = out_rd_q;
  assign port_a_drive_o = out_pa_q;
  assign port_b_drive_o = out_pb_q;
  assign timer_irq_o    = out_irq_q;

`ifndef SYNTHESIS
  // The input side only stalls when the middle stage is occupied and blocked.
  a_stall_needs_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled without a blocked middle stage");

  // The prescaler count never reaches the selected period.
  a_precnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    precnt_q < prescale_period(presel_q))
    else $error("prescale count out of range");

  // A timer load clears the interrupt flag and starts the timer.
  a_load_clears_irq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && is_reg && (act == ACT_WRITE)
     && (reg_sel[RegW-1:2] == REG_LOAD1[RegW-1:2]))
      |=> (!irq_q && running_q && (precnt_q == '0)))
    else $error("timer load did not restart the timer");

  // A held middle stage keeps its result for the next cycle.
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_move) |=> (s1_valid_q && $stable(s1_result)))
    else $error("stalled middle stage lost its data");
`endif

endmodule

>>> tb/tb_ram_io_timer_device_core.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_ram_io_timer_device_core
// Self-checking bench for the RAM, I/O and timer core. Bus reads, bus writes,
// clock ticks and no-op transactions go in with random gaps. A scoreboard keeps
// its own copy of the RAM, port and timer state and predicts every result.
// Results come out under random back-pressure and are checked field by field.
// -----------------------------------------------------------------------------
module tb_ram_io_timer_device_core;
  import ritd_pkg::*;

  localparam int RamBytes = 128;

  // The action field is two bits wide; the fourth code does nothing.
  localparam logic [1:0] ACT_NONE = 2'd3;

  localparam logic [1:0] SEL_DIV1  = 2'd0;
  localparam logic [1:0] SEL_DIV8  = 2'd1;
  localparam logic [1:0] SEL_DIV64 = 2'd2;
  localparam logic [1:0] SEL_DIV1K = 2'd3;

  typedef struct {
    logic [7:0] rd;
    logic [7:0] pa;
    logic [7:0] pb;
    logic       irq;
  } result_t;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [1:0] action_i;
  logic [7:0] address_i;
  logic [7:0] write_data_i;
  logic [7:0] port_a_pins_i;
  logic [7:0] port_b_pins_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [7:0] read_data_o;
  logic [7:0] port_a_drive_o;
  logic [7:0] port_b_drive_o;
  logic       timer_irq_o;

  ram_io_timer_device_core #(
    .RAM_BYTES(RamBytes)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .action_i      (action_i),
    .address_i     (address_i),
    .write_data_i  (write_data_i),
    .port_a_pins_i (port_a_pins_i),
    .port_b_pins_i (port_b_pins_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .read_data_o   (read_data_o),
    .port_a_drive_o(port_a_drive_o),
    .port_b_drive_o(port_b_drive_o),
    .timer_irq_o   (timer_irq_o)
  );

  class io_timer_scoreboard;
    logic [7:0]  ram_image [RamBytes];
    logic [7:0]  latch_a, latch_b, dir_a, dir_b, count;
    logic [1:0]  prescale_sel;
    logic [10:0] prescale_cnt;
    bit          running, irq;
    result_t     predicted_results[$];
    int          errors, n_read, n_write, n_tick, n_noop, n_underflow, n_checked;

    function new();
      foreach (ram_image[i]) ram_image[i] = 8'h00;
      latch_a = 8'h00;
      latch_b = 8'h00;
      dir_a = 8'h00;
      dir_b = 8'h00;
      count = 8'h00;
      prescale_sel = SEL_DIV1;
      prescale_cnt = '0;
      running = 1'b0;
      irq = 1'b0;
    endfunction

    // Advances the copy of the state by one accepted transaction and queues
    // the result that the core should return for it.
    function void note_transaction(logic [1:0] act, logic [7:0] adr, logic [7:0] wd,
                                   logic [7:0] pins_a, logic [7:0] pins_b);
      result_t     r;
      logic [10:0] period;
      r.rd = 8'h00;
      case (act)
        ACT_READ: begin
          n_read++;
          if (!adr[7]) begin
            r.rd = ram_image[adr % RamBytes];
          end else begin
            case (adr[RegW-1:0])
              REG_PA_DATA: r.rd = (latch_a & dir_a) | (pins_a & ~dir_a);
              REG_PA_DIR:  r.rd = dir_a;
              REG_PB_DATA: r.rd = (latch_b & dir_b) | (pins_b & ~dir_b);
              REG_PB_DIR:  r.rd = dir_b;
              REG_TIMER:   r.rd = count;
              REG_STATUS: begin
                r.rd = count;
                irq = 1'b0;
              end
              default: r.rd = UNMAPPED_BYTE;
            endcase
          end
        end
        ACT_WRITE: begin
          n_write++;
          if (!adr[7]) begin
            ram_image[adr % RamBytes] = wd;
          end else begin
            case (adr[RegW-1:0])
              REG_PA_DATA: latch_a = wd;
              REG_PA_DIR:  dir_a = wd;
              REG_PB_DATA: latch_b = wd;
              REG_PB_DIR:  dir_b = wd;
              REG_LOAD1, REG_LOAD8, REG_LOAD64, REG_LOAD1K: begin
                prescale_sel = adr[1:0];
                count = wd;
                prescale_cnt = '0;
                running = 1'b1;
                irq = 1'b0;
              end
              default: ;
            endcase
          end
        end
        ACT_TICK: begin
          n_tick++;
          if (running) begin
            case (prescale_sel)
              SEL_DIV1:  period = 11'd1;
              SEL_DIV8:  period = 11'd8;
              SEL_DIV64: period = 11'd64;
              default:   period = 11'd1024;
            endcase
            prescale_cnt = prescale_cnt + 11'd1;
            if (prescale_cnt >= period) begin
              prescale_cnt = '0;
              if (count == 8'h00) begin
                irq = 1'b1;
                count = 8'hFF;
                n_underflow++;
              end else begin
                count = count - 8'd1;
              end
            end
          end
        end
        default: n_noop++;
      endcase
      r.pa = latch_a & dir_a;
      r.pb = latch_b & dir_b;
      r.irq = irq;
      predicted_results.push_back(r);
    endfunction

    function void check_result(logic [7:0] rd, logic [7:0] pa, logic [7:0] pb, logic irq_o);
      result_t e;
      if (predicted_results.size() == 0) begin
        $error("unexpected result: read_data %02h with nothing predicted", rd);
        errors++;
        return;
      end
      e = predicted_results.pop_front();
      n_checked++;
      if (rd !== e.rd) begin
        $error("read_data mismatch: expected %02h, got %02h", e.rd, rd);
        errors++;
      end
      if (pa !== e.pa) begin
        $error("port_a_drive mismatch: expected %02h, got %02h", e.pa, pa);
        errors++;
      end
      if (pb !== e.pb) begin
        $error("port_b_drive mismatch: expected %02h, got %02h", e.pb, pb);
        errors++;
      end
      if (irq_o !== e.irq) begin
        $error("timer_irq mismatch: expected %0b, got %0b", e.irq, irq_o);
        errors++;
      end
    endfunction
  endclass

  io_timer_scoreboard sb;
  int items_sent;
  int run_left[2];
  int run_mode[2];

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("tb_ram_io_timer_device_core failed");
    $finish;
  end

  // Gap before the next transaction on one side (0 = sender, 1 = receiver).
  // Stretches of no gaps, short gaps and long gaps alternate.
  function automatic int next_gap(int side);
    if (run_left[side] == 0) begin
      run_left[side] = $urandom_range(8, 60);
      run_mode[side] = $urandom_range(0, 2);
    end
    run_left[side]--;
    case (run_mode[side])
      0:       return 0;
      1:       return $urandom_range(0, 3);
      default: return $urandom_range(0, 18);
    endcase
  endfunction

  function automatic logic [7:0] rbyte();
    return 8'($urandom_range(0, 255));
  endfunction

  // Any of the four mirrors of a register.
  function automatic logic [7:0] reg_addr(logic [RegW-1:0] r);
    return {1'b1, 2'($urandom_range(0, 3)), r};
  endfunction

  task automatic send_item(logic [1:0] act, logic [7:0] adr, logic [7:0] wd,
                           logic [7:0] pins_a, logic [7:0] pins_b);
    int gap;
    gap = next_gap(0);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    action_i      <= act;
    address_i     <= adr;
    write_data_i  <= wd;
    port_a_pins_i <= pins_a;
    port_b_pins_i <= pins_b;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_transaction(act, adr, wd, pins_a, pins_b);
    items_sent++;
  endtask

  task automatic run_directed();
    send_item(ACT_READ, 8'h00, 8'h00, 8'h00, 8'h00);
    send_item(ACT_WRITE, 8'h00, 8'hFF, 8'hFF, 8'hFF);
    send_item(ACT_WRITE, 8'h7F, 8'hA5, 8'h00, 8'h00);
    send_item(ACT_READ, 8'h7F, 8'h00, 8'h00, 8'h00);
    send_item(ACT_READ, 8'h00, 8'h00, 8'hFF, 8'hFF);
    send_item(ACT_WRITE, {3'b100, REG_PA_DIR}, 8'hF0, 8'h00, 8'h00);
    send_item(ACT_WRITE, {3'b100, REG_PA_DATA}, 8'h5A, 8'h00, 8'h00);
    send_item(ACT_READ, {3'b100, REG_PA_DATA}, 8'h00, 8'hFF, 8'h00);
    send_item(ACT_READ, {3'b111, REG_PA_DATA}, 8'h00, 8'h00, 8'hFF);
    send_item(ACT_WRITE, {3'b101, REG_PB_DIR}, 8'h0F, 8'h00, 8'h00);
    send_item(ACT_WRITE, {3'b110, REG_PB_DATA}, 8'hFF, 8'h00, 8'h00);
    send_item(ACT_READ, {3'b101, REG_PB_DATA}, 8'h00, 8'h00, 8'hFF);
    send_item(ACT_READ, {3'b111, REG_PB_DIR}, 8'h00, 8'h00, 8'h00);
    // The timer has never been loaded, so this tick changes nothing.
    send_item(ACT_TICK, 8'hFF, 8'hFF, 8'h00, 8'h00);
    send_item(ACT_WRITE, {3'b100, REG_TIMER}, 8'h77, 8'h00, 8'h00);
    send_item(ACT_WRITE, {3'b100, REG_STATUS}, 8'h77, 8'h00, 8'h00);
    send_item(ACT_WRITE, 8'hFF, 8'h33, 8'h00, 8'h00);
    send_item(ACT_READ, 8'hFF, 8'h00, 8'h00, 8'h00);
    send_item(ACT_WRITE, {3'b111, REG_LOAD1}, 8'h01, 8'h00, 8'h00);
    repeat (3) send_item(ACT_TICK, 8'h00, 8'h00, 8'h00, 8'h00);
    send_item(ACT_READ, {3'b100, REG_TIMER}, 8'h00, 8'h00, 8'h00);
    send_item(ACT_NONE, 8'h95, 8'h00, 8'hFF, 8'hFF);
    send_item(ACT_READ, {3'b110, REG_STATUS}, 8'h00, 8'h00, 8'h00);
    send_item(ACT_READ, {3'b100, REG_STATUS}, 8'h00, 8'h00, 8'h00);
  endtask

  // Load the timer, tick it for a while with a few reads in between and, half of the
  // time, finish with a status read.
  task automatic timer_sequence();
    logic [1:0] sel;
    logic [7:0] start;
    int         roll, period, n;
    roll = $urandom_range(0, 19);
    if (roll < 10)      sel = SEL_DIV1;
    else if (roll < 16) sel = SEL_DIV8;
    else if (roll < 19) sel = SEL_DIV64;
    else                sel = SEL_DIV1K;
    case (sel)
      SEL_DIV1:  period = 1;
      SEL_DIV8:  period = 8;
      SEL_DIV64: period = 64;
      default:   period = 1024;
    endcase
    start = ($urandom_range(0, 3) == 0) ? rbyte() : 8'($urandom_range(0, 3));
    n = $urandom_range(1, (int'(start) + 2) * period);
    if (n > 120) n = $urandom_range(60, 120);
    send_item(ACT_WRITE, reg_addr(REG_LOAD1 | RegW'(sel)), start, rbyte(), rbyte());
    repeat (n) begin
      if ($urandom_range(0, 11) == 0)
        send_item(ACT_READ, reg_addr($urandom_range(0, 1) ? REG_TIMER : REG_STATUS),
                  rbyte(), rbyte(), rbyte());
      else
        send_item(ACT_TICK, rbyte(), rbyte(), rbyte(), rbyte());
    end
    if ($urandom_range(0, 1))
      send_item(ACT_READ, reg_addr(REG_STATUS), rbyte(), rbyte(), rbyte());
  endtask

  task automatic run_random();
    logic [RegW-1:0] r;
    int              s;
    while (items_sent < 100) begin
      s = $urandom_range(0, 9);
      if (s < 4) begin
        send_item($urandom_range(0, 1) ? ACT_WRITE : ACT_READ, 8'($urandom_range(0, 127)),
                  rbyte(), rbyte(), rbyte());
      end else if (s < 6) begin
        case ($urandom_range(0, 7))
          0:       r = REG_PA_DATA;
          1:       r = REG_PA_DIR;
          2:       r = REG_PB_DATA;
          3:       r = REG_PB_DIR;
          4:       r = REG_TIMER;
          5:       r = REG_STATUS;
          default: r = RegW'($urandom_range(0, 31));
        endcase
        send_item($urandom_range(0, 1) ? ACT_WRITE : ACT_READ, reg_addr(r),
                  rbyte(), rbyte(), rbyte());
      end else if (s < 9) begin
        timer_sequence();
      end else begin
        case ($urandom_range(0, 2))
          0:       send_item(ACT_NONE, rbyte(), rbyte(), rbyte(), rbyte());
          1:       send_item(ACT_TICK, rbyte(), rbyte(), rbyte(), rbyte());
          default: send_item($urandom_range(0, 1) ? ACT_WRITE : ACT_READ, rbyte(),
                             rbyte(), rbyte(), rbyte());
        endcase
      end
    end
  endtask

  // A full divide-by-1024 period needs over a thousand ticks, so the slowest
  // prescale gets one run of its own, with RAM and port traffic mixed in.
  task automatic run_long_prescale();
    int ticks;
    ticks = 0;
    send_item(ACT_WRITE, reg_addr(REG_LOAD1K), 8'h00, rbyte(), rbyte());
    while (ticks < 1030) begin
      if ($urandom_range(0, 19) == 0) begin
        case ($urandom_range(0, 3))
          0: send_item(ACT_READ, 8'($urandom_range(0, 127)), rbyte(), rbyte(), rbyte());
          1: send_item(ACT_WRITE, 8'($urandom_range(0, 127)), rbyte(), rbyte(), rbyte());
          2: send_item(ACT_READ, reg_addr(REG_TIMER), rbyte(), rbyte(), rbyte());
          default: send_item(ACT_READ, reg_addr(REG_PA_DATA), rbyte(), rbyte(), rbyte());
        endcase
      end else begin
        send_item(ACT_TICK, rbyte(), rbyte(), rbyte(), rbyte());
        ticks++;
      end
    end
    send_item(ACT_READ, reg_addr(REG_STATUS), rbyte(), rbyte(), rbyte());
    send_item(ACT_READ, reg_addr(REG_STATUS), rbyte(), rbyte(), rbyte());
  endtask

  initial begin
    int gap;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      gap = next_gap(1);
      if (gap > 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      sb.check_result(read_data_o, port_a_drive_o, port_b_drive_o, timer_irq_o);
      @(negedge clk_i);
    end
  end

  initial begin
    sb = new();
    items_sent = 0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    action_i = ACT_READ;
    address_i = 8'h00;
    write_data_i = 8'h00;
    port_a_pins_i = 8'h00;
    port_b_pins_i = 8'h00;
    out_stall_i = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    run_directed();
    run_random();
    run_long_prescale();
    @(negedge clk_i);
    in_valid_i <= 1'b0;

    while (sb.predicted_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Checked %0d results: %0d reads, %0d writes, %0d ticks, %0d no-op transactions.",
             sb.n_checked, sb.n_read, sb.n_write, sb.n_tick, sb.n_noop);
    $display("Timer underflows seen: %0d, including a full divide-by-1024 period.",
             sb.n_underflow);
    if (sb.errors == 0) begin
      $display("tb_ram_io_timer_device_core passed");
    end else begin
      $display("tb_ram_io_timer_device_core failed");
    end
    $finish;
  end

endmodule
